/* rtl/tpg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_pkg
// Shared types, codes and constants of the transient punch gain block.
// ----------------------------------------------------------------------------
package tpg_pkg;

  localparam int MAX_TRANSIENTS = 256;
  localparam int ADDR_W         = $clog2(MAX_TRANSIENTS);
  localparam int CNT_W          = ADDR_W + 1;

  localparam logic [16:0] UNITY       = 17'd65536;
  localparam logic [29:0] LOG2_10_20  = 30'd713378628;
  localparam logic [23:0] GAIN_MAX    = 24'hFFFFFF;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CFG_TIME_RATIO = 3'd0,
    CFG_PUNCH      = 3'd1,
    CFG_MAX_DB     = 3'd2,
    CFG_PRE_RISE   = 3'd3,
    CFG_DECAY      = 3'd4
  } cfg_index_t;

  typedef logic [15:0][31:0] root_tab_t;

  // Truncated integer square root, evaluated at elaboration only.
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Entry k-1 holds 2^(2^-k) in Q2.30, built by repeated square roots.
  function automatic root_tab_t make_roots();
    root_tab_t   tab;
    logic [63:0] r;
    r = 64'h1 << 31;
    for (int k = 0; k < 16; k++) begin
      r = isqrt64(r << 30);
      tab[k] = r[31:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOT_TAB = make_roots();

endpackage

/* rtl/tpg_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_in_if
// Input channel: table commands and gain queries.
// ----------------------------------------------------------------------------
interface tpg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] transient_time;
  logic        transient_valid;
  logic [31:0] playback_time;

  modport source (output valid, kind, transient_time, transient_valid, playback_time,
                  input ready);
  modport sink   (input valid, kind, transient_time, transient_valid, playback_time,
                  output ready);
endinterface

/* rtl/tpg_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_out_if
// Result channel: gain, envelope and status.
// ----------------------------------------------------------------------------
interface tpg_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] gain;
  logic [16:0] envelope;
  logic        status;

  modport source (output valid, gain, envelope, status, input ready);
  modport sink   (input valid, gain, envelope, status, output ready);
endinterface

/* rtl/transient_punch_gain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transient_punch_gain
// Punch gain from a table of transient times held in a single-port memory.
// ----------------------------------------------------------------------------
// Clear, append and unused kinds give their result in the cycle after
// acceptance. A query's time grows with the search steps (up to nine), the
// invalid entries skipped in the backward scan and the envelope divisions
// (up to two); the bit-serial divider and the single table read port set it.
// Throughput: one transaction at a time; the next is taken once the result
// register is free. Reset clears the count and loads register defaults only.
// ----------------------------------------------------------------------------
module transient_punch_gain (
  input  logic                         clk,
  input  logic                         rst_n,
  tpg_in_if.sink                       in_ch,
  tpg_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [23:0]                  cfg_wdata
);
  import tpg_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_S_CHK, ST_S_RD, ST_S_CMP, ST_N_CHK, ST_N_RD, ST_N_USE,
    ST_B_INIT, ST_B_CHK, ST_B_RD, ST_B_USE, ST_E0, ST_E1, ST_DIV,
    ST_GAIN, ST_G_MUL, ST_G_EXP, ST_G_POW, ST_G_OUT, ST_FIN
  } state_t;

  // Configuration registers.
  logic [23:0] time_ratio_r;
  logic [16:0] punch_r;
  logic [12:0] max_db_r;
  logic [16:0] pre_rise_r;
  logic [19:0] decay_r;

  // Transient table: bit 32 is the valid flag, bits 31:0 the time.
  logic [32:0]       mem [MAX_TRANSIENTS];
  logic [32:0]       rd_r;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;

  state_t      state_r, ret_r;
  logic [CNT_W-1:0] count_r, lo_r, hi_r, mid_r, j_r;
  logic [31:0] p_r;
  logic [39:0] scaled_r, t_r, start_r;
  logic [31:0] el_r;
  logic [16:0] dur_r, env_r;
  logic        lt_r, ramp_r;
  logic [19:0] rem_r, den_r;
  logic [15:0] q_r;
  logic [4:0]  dcnt_r;
  logic [29:0] pa_r;
  logic [46:0] prod_r;
  logic [20:0] e_r;
  logic [31:0] m_r;
  logic [3:0]  k_r;
  logic [23:0] gres_r;

  logic        ov_r, ostat_r;
  logic [23:0] ogain_r;
  logic [16:0] oenv_r;

  logic        accept;
  logic        out_free;
  logic        ov_set;
  logic [CNT_W:0] mid_sum;
  logic [23:0] ratio_eff;
  logic [55:0] scale_prod;
  logic [16:0] amt;
  logic [20:0] div_r2;
  logic [16:0] div_v;
  logic [63:0] pow_prod;
  logic [60:0] e_prod;
  logic [38:0] g_shift;
  logic [39:0] diff_pt;
  logic        gt_pre;

  assign out_free     = !ov_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && out_free;
  assign accept       = in_ch.valid && in_ch.ready;
  // A new result is loaded by a non-query transaction or at the end of a query.
  assign ov_set       = (accept && (kind_t'(in_ch.kind) != KIND_QUERY)) ||
                        ((state_r == ST_FIN) && out_free);

  assign out_ch.valid    = ov_r;
  assign out_ch.gain     = ogain_r;
  assign out_ch.envelope = oenv_r;
  assign out_ch.status   = ostat_r;

  assign mid_sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign ratio_eff  = (time_ratio_r == '0) ? 24'd1 : time_ratio_r;
  // A zero ratio acts as one LSB; the scaled time keeps 40 bits.
  assign scale_prod = {24'b0, rd_r[31:0]} * {32'b0, ratio_eff};
  assign amt        = (punch_r > UNITY) ? UNITY : punch_r;
  assign div_r2     = {rem_r, 1'b0};
  assign div_v      = ramp_r ? {1'b0, q_r} : UNITY - {1'b0, q_r};
  assign pow_prod   = {32'b0, m_r} * {32'b0, ROOT_TAB[k_r]};
  assign e_prod     = {30'b0, prod_r[46:16]} * {31'b0, LOG2_10_20};
  assign g_shift    = ({7'b0, m_r} << e_r[18:16]) >> 14;
  assign diff_pt    = {8'b0, p_r} - t_r;
  assign gt_pre     = t_r > {23'b0, pre_rise_r};

  // Single read port, address chosen by the search, lookup and scan phases.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mid_sum[ADDR_W:1];
    unique case (state_r)
      ST_S_CHK: begin
        rd_en   = lo_r < hi_r;
        rd_addr = mid_sum[ADDR_W:1];
      end
      ST_N_CHK: begin
        rd_en   = lo_r < count_r;
        rd_addr = lo_r[ADDR_W-1:0];
      end
      ST_B_CHK: begin
        rd_en   = 1'b1;
        rd_addr = j_r[ADDR_W-1:0];
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign wr_en = accept && (kind_t'(in_ch.kind) == KIND_APPEND) &&
                 (count_r < CNT_W'(MAX_TRANSIENTS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[ADDR_W-1:0]] <= {in_ch.transient_valid,
                                   in_ch.transient_time[31] ? 32'd0 : in_ch.transient_time};
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_ratio_r <= 24'd65536;
      punch_r      <= 17'd0;
      max_db_r     <= 13'd1536;
      pre_rise_r   <= 17'd328;
      decay_r      <= 20'd6554;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_TIME_RATIO: time_ratio_r <= cfg_wdata;
        CFG_PUNCH:      punch_r      <= cfg_wdata[16:0];
        CFG_MAX_DB:     max_db_r     <= cfg_wdata[12:0];
        CFG_PRE_RISE:   pre_rise_r   <= cfg_wdata[16:0];
        CFG_DECAY:      decay_r      <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  // Sequencer: binary search, lookup of the following entry, backward scan for
  // the nearest earlier valid entry, envelope division and gain exponent.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (ov_set) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            ogain_r <= {7'b0, UNITY};
            oenv_r  <= '0;
            ostat_r <= (kind_t'(in_ch.kind) == KIND_APPEND) &&
                       !(count_r < CNT_W'(MAX_TRANSIENTS));
            unique case (kind_t'(in_ch.kind))
              KIND_CLEAR: begin
                count_r <= '0;
              end
              KIND_APPEND: begin
                if (count_r < CNT_W'(MAX_TRANSIENTS)) count_r <= count_r + 1'b1;
              end
              KIND_QUERY: begin
                p_r   <= in_ch.playback_time;
                env_r <= '0;
                lo_r  <= '0;
                hi_r  <= count_r;
                if (count_r == '0) begin
                  // An empty table acts as one transient at time zero.
                  t_r     <= '0;
                  ret_r   <= ST_GAIN;
                  state_r <= ST_E0;
                end else begin
                  state_r <= ST_S_CHK;
                end
              end
              KIND_NONE: ;
            endcase
          end
        end
        ST_S_CHK: begin
          mid_r   <= mid_sum[CNT_W:1];
          state_r <= (lo_r < hi_r) ? ST_S_RD : ST_N_CHK;
        end
        ST_S_RD: begin
          scaled_r <= scale_prod[55:16];
          state_r  <= ST_S_CMP;
        end
        ST_S_CMP: begin
          if (rd_r[32] && (scaled_r <= {8'b0, p_r})) lo_r <= mid_r + 1'b1;
          else hi_r <= mid_r;
          state_r <= ST_S_CHK;
        end
        ST_N_CHK: begin
          state_r <= (lo_r < count_r) ? ST_N_RD : ST_B_INIT;
        end
        ST_N_RD: begin
          scaled_r <= scale_prod[55:16];
          state_r  <= ST_N_USE;
        end
        ST_N_USE: begin
          if (rd_r[32]) begin
            t_r     <= scaled_r;
            ret_r   <= ST_B_INIT;
            state_r <= ST_E0;
          end else begin
            state_r <= ST_B_INIT;
          end
        end
        ST_B_INIT: begin
          j_r     <= lo_r - 1'b1;
          state_r <= (lo_r == '0) ? ST_GAIN : ST_B_CHK;
        end
        ST_B_CHK: begin
          state_r <= ST_B_RD;
        end
        ST_B_RD: begin
          scaled_r <= scale_prod[55:16];
          if (rd_r[32]) begin
            state_r <= ST_B_USE;
          end else if (j_r == '0) begin
            state_r <= ST_GAIN;
          end else begin
            j_r     <= j_r - 1'b1;
            state_r <= ST_B_CHK;
          end
        end
        ST_B_USE: begin
          t_r     <= scaled_r;
          ret_r   <= ST_GAIN;
          state_r <= ST_E0;
        end
        ST_E0: begin
          lt_r    <= {8'b0, p_r} < t_r;
          start_r <= gt_pre ? t_r - {23'b0, pre_rise_r} : 40'd0;
          dur_r   <= gt_pre ? pre_rise_r : t_r[16:0];
          el_r    <= diff_pt[31:0];
          state_r <= ST_E1;
        end
        ST_E1: begin
          q_r    <= '0;
          dcnt_r <= 5'd16;
          ramp_r <= lt_r;
          if (lt_r) begin
            if ((dur_r == '0) || ({8'b0, p_r} < start_r)) begin
              state_r <= ret_r;
            end else begin
              rem_r   <= 20'(p_r - start_r[31:0]);
              den_r   <= {3'b0, dur_r};
              state_r <= ST_DIV;
            end
          end else begin
            if (el_r >= {12'b0, decay_r}) begin
              state_r <= ret_r;
            end else begin
              rem_r   <= el_r[19:0];
              den_r   <= decay_r;
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (dcnt_r == '0) begin
            if (div_v > env_r) env_r <= div_v;
            state_r <= ret_r;
          end else begin
            if (div_r2 >= {1'b0, den_r}) begin
              rem_r <= 20'(div_r2 - {1'b0, den_r});
              q_r   <= {q_r[14:0], 1'b1};
            end else begin
              rem_r <= div_r2[19:0];
              q_r   <= {q_r[14:0], 1'b0};
            end
            dcnt_r <= dcnt_r - 1'b1;
          end
        end
        ST_GAIN: begin
          gres_r <= {7'b0, UNITY};
          pa_r   <= {17'b0, max_db_r} * {13'b0, amt};
          state_r <= ((amt == '0) || (env_r == '0)) ? ST_FIN : ST_G_MUL;
        end
        ST_G_MUL: begin
          prod_r  <= {17'b0, pa_r} * {30'b0, env_r};
          state_r <= ST_G_EXP;
        end
        ST_G_EXP: begin
          e_r     <= e_prod[60:40];
          m_r     <= 32'h4000_0000;
          k_r     <= '0;
          state_r <= ST_G_POW;
        end
        ST_G_POW: begin
          if (e_r[4'd15 - k_r]) m_r <= pow_prod[61:30];
          k_r <= k_r + 1'b1;
          if (k_r == 4'd15) state_r <= ST_G_OUT;
        end
        ST_G_OUT: begin
          if ((e_r[20:19] != 2'b0) || (g_shift > {15'b0, GAIN_MAX})) gres_r <= GAIN_MAX;
          else gres_r <= g_shift[23:0];
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            ogain_r <= gres_r;
            oenv_r  <= env_r;
            ostat_r <= 1'b0;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TRANSIENTS))
    else $error("transient count beyond table depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_ch.kind == KIND_CLEAR) |=> (count_r == '0))
    else $error("clear did not empty the table");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_ch.kind == KIND_APPEND) && (count_r == CNT_W'(MAX_TRANSIENTS))
    |=> out_ch.valid && out_ch.status)
    else $error("dropped append not flagged");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_ch.kind == KIND_QUERY) |=> !in_ch.ready)
    else $error("new transaction taken during a query");
`endif

endmodule
